FILE: rtl/assert_macros.svh
// Assertion macros shared by the support-point RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle while reset is high.
`define BSP_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("support point check failed");

// Clocked check that also runs through reset.
`define BSP_ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("support point check failed");

`endif

FILE: rtl/bsp_pkg.sv
// Types, constants and helpers of the box support point pipeline.
package bsp_pkg;

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned HALF_SHIFT  = 17;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [19:0] mat_t;
  typedef logic signed [52:0] prod_t;
  typedef logic signed [55:0] sum_t;
  typedef logic signed [63:0] dprod_t;
  typedef logic signed [65:0] dot_t;

  typedef coord_t [2:0] vec3_t;
  typedef vec3_t [NUM_CORNERS-1:0] corners_t;

  // Pipeline control handed to each stage group.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2
  } reg_idx_t;

  // Corner sign pattern: bit0 x, bit1 y, bit2 z; set means plus half size.
  localparam logic [2:0] CORNER_POS [0:NUM_CORNERS-1] = '{
    3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
  };

  // Round half up from Q.33 to Q16.16, then clamp to the 32-bit range.
  function automatic coord_t round_sat(input sum_t s);
    sum_t                    t;
    logic signed [38:0]      r;
    begin
      t = s + (sum_t'(1) <<< (HALF_SHIFT - 1));
      r = 39'(t >>> HALF_SHIFT);
      if (r > 39'sd2147483647) begin
        round_sat = 32'sh7fffffff;
      end else if (r < -39'sd2147483648) begin
        round_sat = 32'sh80000000;
      end else begin
        round_sat = r[31:0];
      end
    end
  endfunction

endpackage

FILE: rtl/bsp_transform.sv
// Stages 1-2: half-size products, then the eight world corners.
module bsp_transform (
  input  logic                clk,
  input  logic                rst,
  input  bsp_pkg::pipe_ctl_t  ctl,
  input  logic [59:0]         x_axis_row,
  input  logic [59:0]         y_axis_row,
  input  logic [59:0]         z_axis_row,
  input  logic signed [31:0]  shift_x,
  input  logic signed [31:0]  shift_y,
  input  logic signed [31:0]  shift_z,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  input  logic signed [31:0]  dir_z,
  input  logic [31:0]         box_width,
  input  logic [31:0]         box_height,
  input  logic [31:0]         box_depth,
  output logic                valid2,
  output bsp_pkg::corners_t   corners,
  output bsp_pkg::vec3_t      dir2
);
  import bsp_pkg::*;

  logic [59:0]  rows [0:2];
  logic [31:0]  halfs [0:2];
  prod_t        prod_next [0:2][0:2];
  prod_t        prod [0:2][0:2];
  vec3_t        shift1;
  vec3_t        dir1;
  logic         valid1;
  corners_t     corners_next;

  assign rows[0]  = x_axis_row;
  assign rows[1]  = y_axis_row;
  assign rows[2]  = z_axis_row;
  assign halfs[0] = box_width;
  assign halfs[1] = box_height;
  assign halfs[2] = box_depth;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[i][j] = prod_t'($signed({1'b0, halfs[i]}) *
                                  $signed(mat_t'(rows[i][20*j +: 20])));
      end
    end
  end

  always_comb begin
    sum_t s;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int j = 0; j < 3; j++) begin
        s = sum_t'($signed(shift1[j])) <<< HALF_SHIFT;
        for (int i = 0; i < 3; i++) begin
          if (CORNER_POS[k][i]) begin
            s = s + sum_t'(prod[i][j]);
          end else begin
            s = s - sum_t'(prod[i][j]);
          end
        end
        corners_next[k][j] = round_sat(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (ctl.en) begin
      valid1 <= ctl.valid;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod    <= prod_next;
      shift1  <= '{shift_z, shift_y, shift_x};
      dir1    <= '{dir_z, dir_y, dir_x};
      corners <= corners_next;
      dir2    <= dir1;
    end
  end

endmodule

FILE: rtl/bsp_dot.sv
// Stages 3-4: corner by direction products, then one dot per corner.
module bsp_dot (
  input  logic                clk,
  input  logic                rst,
  input  bsp_pkg::pipe_ctl_t  ctl,
  input  bsp_pkg::corners_t   corners,
  input  bsp_pkg::vec3_t      dir,
  output logic                valid4,
  output bsp_pkg::corners_t   corners4,
  output bsp_pkg::dot_t       dots [0:bsp_pkg::NUM_CORNERS-1]
);
  import bsp_pkg::*;

  dprod_t   dprod [0:NUM_CORNERS-1][0:2];
  corners_t corners3;
  logic     valid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else if (ctl.en) begin
      valid3 <= ctl.valid;
      valid4 <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        for (int j = 0; j < 3; j++) begin
          dprod[k][j] <= $signed(corners[k][j]) * $signed(dir[j]);
        end
        dots[k] <= dot_t'(dprod[k][0]) + dot_t'(dprod[k][1]) + dot_t'(dprod[k][2]);
      end
      corners3 <= corners;
      corners4 <= corners3;
    end
  end

endmodule

FILE: rtl/bsp_select.sv
// Stages 5-6: tournament over the dots, lowest index kept on ties.
module bsp_select (
  input  logic                clk,
  input  logic                rst,
  input  bsp_pkg::pipe_ctl_t  ctl,
  input  bsp_pkg::corners_t   corners,
  input  bsp_pkg::dot_t       dots [0:bsp_pkg::NUM_CORNERS-1],
  output logic                out_valid,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic [2:0]          corner_index
);
  import bsp_pkg::*;

  dot_t        l1_dot [0:3];
  logic [2:0]  l1_idx [0:3];
  dot_t        l2_dot_next [0:1];
  logic [2:0]  l2_idx_next [0:1];
  dot_t        l2_dot [0:1];
  logic [2:0]  l2_idx [0:1];
  vec3_t       l2_pt [0:1];
  logic        valid5;
  logic [2:0]  win_idx;
  vec3_t       win_pt;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      if (dots[2*n+1] > dots[2*n]) begin
        l1_dot[n] = dots[2*n+1];
        l1_idx[n] = 3'(2*n+1);
      end else begin
        l1_dot[n] = dots[2*n];
        l1_idx[n] = 3'(2*n);
      end
    end
    for (int n = 0; n < 2; n++) begin
      if (l1_dot[2*n+1] > l1_dot[2*n]) begin
        l2_dot_next[n] = l1_dot[2*n+1];
        l2_idx_next[n] = l1_idx[2*n+1];
      end else begin
        l2_dot_next[n] = l1_dot[2*n];
        l2_idx_next[n] = l1_idx[2*n];
      end
    end
  end

  always_comb begin
    if (l2_dot[1] > l2_dot[0]) begin
      win_idx = l2_idx[1];
      win_pt  = l2_pt[1];
    end else begin
      win_idx = l2_idx[0];
      win_pt  = l2_pt[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5    <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      valid5    <= ctl.valid;
      out_valid <= valid5;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int n = 0; n < 2; n++) begin
        l2_dot[n] <= l2_dot_next[n];
        l2_idx[n] <= l2_idx_next[n];
        l2_pt[n]  <= corners[l2_idx_next[n]];
      end
      point_x      <= win_pt[0];
      point_y      <= win_pt[1];
      point_z      <= win_pt[2];
      corner_index <= win_idx;
    end
  end

endmodule

FILE: rtl/box_support_point.sv
// Top level of the box support point pipeline with its register port.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  rows, shift_x..z, dir_x..z
//  result    out        out_valid / out_stall point_x..z, corner_index
//  config    in         psel/penable/pwrite  paddr, pwdata, prdata
//
// Six register stages, one item per cycle while the result is not stalled;
// the depth follows the two multiplier banks and the tree.
// Reset clears all valid bits and sets the three sizes to 1.0.
// A stalled result freezes the whole pipeline; nothing is dropped or redone.
// Bubbles advance freely while the output is empty or being taken.
`include "assert_macros.svh"

module box_support_point (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [59:0]        x_axis_row,
  input  logic [59:0]        y_axis_row,
  input  logic [59:0]        z_axis_row,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [2:0]         corner_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bsp_pkg::*;

  logic       en;
  logic [31:0] box_width;
  logic [31:0] box_height;
  logic [31:0] box_depth;
  reg_idx_t   reg_idx;
  logic       valid2;
  logic       valid4;
  corners_t   corners2;
  corners_t   corners4;
  vec3_t      dir2;
  dot_t       dots [0:NUM_CORNERS-1];

  // Advance everything unless a finished item at the output is stalled.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign pready   = 1'b1;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= 32'h0001_0000;
      box_height <= 32'h0001_0000;
      box_depth  <= 32'h0001_0000;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WIDTH:  box_width  <= pwdata;
        REG_HEIGHT: box_height <= pwdata;
        REG_DEPTH:  box_depth  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = box_width;
      REG_HEIGHT: prdata = box_height;
      REG_DEPTH:  prdata = box_depth;
      default:    prdata = '0;
    endcase
  end

  bsp_transform u_transform (
    .clk        (clk),
    .rst        (rst),
    .ctl        ('{en: en, valid: in_valid}),
    .x_axis_row (x_axis_row),
    .y_axis_row (y_axis_row),
    .z_axis_row (z_axis_row),
    .shift_x    (shift_x),
    .shift_y    (shift_y),
    .shift_z    (shift_z),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .box_width  (box_width),
    .box_height (box_height),
    .box_depth  (box_depth),
    .valid2     (valid2),
    .corners    (corners2),
    .dir2       (dir2)
  );

  bsp_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .ctl      ('{en: en, valid: valid2}),
    .corners  (corners2),
    .dir      (dir2),
    .valid4   (valid4),
    .corners4 (corners4),
    .dots     (dots)
  );

  bsp_select u_select (
    .clk          (clk),
    .rst          (rst),
    .ctl          ('{en: en, valid: valid4}),
    .corners      (corners4),
    .dots         (dots),
    .out_valid    (out_valid),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .corner_index (corner_index)
  );

  // Pipeline comes out of reset empty.
  `BSP_ASSERT_ANY(a_reset_empty, clk, rst |=> !out_valid)
  // A frozen pipeline keeps the waiting item.
  `BSP_ASSERT_CLK(a_freeze_keeps, clk, rst, !en |=> out_valid)
  // Frozen result holds its payload.
  `BSP_ASSERT_CLK(a_freeze_holds, clk, rst, !en |=> $stable(point_x) && $stable(corner_index))

endmodule

FILE: verif/box_support_point_test.sv
// Testbench for the box support point pipeline: directed and random transforms checked against a model.
`timescale 1ns / 1ps

module box_support_point_test;
  import bsp_pkg::*;

  typedef struct {
    logic [59:0] rx, ry, rz;
    logic signed [31:0] sx, sy, sz, dx, dy, dz;
  } query_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [2:0] idx;
  } support_t;

  // Scoreboard: predicts the support corner of each accepted query and checks results.
  class support_board;
    logic [31:0] size [3];
    support_t pending [$];
    int errors;

    function new();
      size[0] = 32'h10000; size[1] = 32'h10000; size[2] = 32'h10000;
      errors = 0;
    endfunction

    // Round half up from Q.33 to Q16.16 and clamp.
    function logic signed [31:0] clamp_round(logic signed [79:0] s);
      logic signed [79:0] t;
      t = (s + 80'sd65536) >>> 17;
      if (t > 80'sd2147483647) return 32'sh7fffffff;
      if (t < -80'sd2147483648) return 32'sh80000000;
      return t[31:0];
    endfunction

    function void note_query(query_t q);
      logic [59:0] rows [3];
      logic signed [31:0] shv [3], dv [3], pt [3];
      logic signed [79:0] acc, c, dot, best_dot;
      logic [2:0] pos;
      support_t best;
      rows[0] = q.rx; rows[1] = q.ry; rows[2] = q.rz;
      shv[0] = q.sx; shv[1] = q.sy; shv[2] = q.sz;
      dv[0] = q.dx; dv[1] = q.dy; dv[2] = q.dz;
      best_dot = 0;
      best = '{0, 0, 0, 0};
      for (int k = 0; k < 8; k++) begin
        pos = CORNER_POS[k];
        dot = 0;
        for (int j = 0; j < 3; j++) begin
          acc = 80'(shv[j]) <<< 17;
          for (int i = 0; i < 3; i++) begin
            c = $signed({48'd0, size[i]});
            if (!pos[i]) c = -c;
            acc += c * 80'($signed(rows[i][20*j +: 20]));
          end
          pt[j] = clamp_round(acc);
          dot += 80'(pt[j]) * 80'(dv[j]);
        end
        if (k == 0 || dot > best_dot) begin
          best_dot = dot;
          best = '{pt[0], pt[1], pt[2], 3'(k)};
        end
      end
      pending.push_back(best);
    endfunction

    function void check_result(support_t r);
      support_t e;
      if (pending.size() == 0) begin
        $error("result with no query outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.px !== e.px) begin $error("point_x exp %h got %h", e.px, r.px); errors++; end
      if (r.py !== e.py) begin $error("point_y exp %h got %h", e.py, r.py); errors++; end
      if (r.pz !== e.pz) begin $error("point_z exp %h got %h", e.pz, r.pz); errors++; end
      if (r.idx !== e.idx) begin
        $error("corner_index exp %0d got %0d", e.idx, r.idx); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [59:0] x_axis_row = 0, y_axis_row = 0, z_axis_row = 0;
  logic signed [31:0] shift_x = 0, shift_y = 0, shift_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic signed [31:0] point_x, point_y, point_z;
  logic [2:0] corner_index;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  support_board board = new();
  int idle_cycles = 0;
  int hold_off = 0;     // cycles of forced output stall, counted by the receiver
  int queries_sent = 0;
  int size_sets = 0;
  bit chaos_stall = 1;

  box_support_point DUT (.*);

  initial forever #5 clk = ~clk;

  // Write one size register during idle; a setup phase then an access phase.
  task automatic write_size(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(r) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.size[r] = v;
    size_sets++;
  endtask

  // Wait until every predicted support has come back, then let the pipe drain.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2: return 20'h10000;
      3: return 20'hf0000;
      4: return 20'(($urandom_range(0, 131071)) - 65536);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 0;
      3: return $signed(32'($urandom_range(0, 2000000)) - 32'd1000000);
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.rx = {rand_entry(), rand_entry(), rand_entry()};
    q.ry = {rand_entry(), rand_entry(), rand_entry()};
    q.rz = {rand_entry(), rand_entry(), rand_entry()};
    q.sx = rand_word(); q.sy = rand_word(); q.sz = rand_word();
    q.dx = rand_word(); q.dy = rand_word(); q.dz = rand_word();
    return q;
  endfunction

  // Offer one query and hold it until accepted.
  task automatic send_query(query_t q);
    in_valid <= 1;
    x_axis_row <= q.rx; y_axis_row <= q.ry; z_axis_row <= q.rz;
    shift_x <= q.sx; shift_y <= q.sy; shift_z <= q.sz;
    dir_x <= q.dx; dir_y <= q.dy; dir_z <= q.dz;
    do @(posedge clk); while (in_stall);
    board.note_query(q);
    queries_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 0;
  endtask

  // Send n random queries in bursts with random gaps.
  task automatic burst_run(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_query(rand_query());
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        stop_sending();
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    stop_sending();
  endtask

  // Receiver: random stall pattern, long hold-off on request, calm stretches.
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      board.check_result('{point_x, point_y, point_z, corner_index});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if (chaos_stall) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 0;
    end
  end

  // Watchdog: fail if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    query_t q;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: identity transform at reset size, each octant direction.
    for (int k = 0; k < 8; k++) begin
      q = '{60'h00000_00000_10000, 60'h00000_10000_00000, 60'h10000_00000_00000,
            0, 0, 0, 0, 0, 0};
      q.dx = k[0] ? 32'sh10000 : -32'sh10000;
      q.dy = k[1] ? 32'sh10000 : -32'sh10000;
      q.dz = k[2] ? 32'sh10000 : -32'sh10000;
      send_query(q);
    end
    // Zero direction picks the first corner.
    q.dx = 0; q.dy = 0; q.dz = 0;
    send_query(q);
    // Extreme entries and shifts force saturation.
    q = '{60'h80000_7ffff_80000, 60'h7ffff_80000_7ffff, 60'h80000_80000_80000,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_query(q);
    q = '{60'hfffff_fffff_fffff, 60'hfffff_fffff_fffff, 60'hfffff_fffff_fffff,
          -1, -1, -1, -1, -1, -1};
    send_query(q);
    stop_sending();
    drain();

    // Maximum size with saturating transforms.
    write_size(REG_WIDTH, 32'hffffffff);
    write_size(REG_HEIGHT, 32'hffffffff);
    write_size(REG_DEPTH, 32'hffffffff);
    send_query(q);
    q.rx = 60'h7ffff_7ffff_7ffff; q.dx = 32'sh7fffffff;
    send_query(q);
    stop_sending();
    drain();

    // Zero size: corners coincide, ties pick the lowest index.
    write_size(REG_WIDTH, 0);
    write_size(REG_HEIGHT, 0);
    write_size(REG_DEPTH, 0);
    for (int k = 0; k < 4; k++) send_query(rand_query());
    stop_sending();
    drain();

    // Random phases over a spread of sizes.
    for (int ph = 0; ph < 6; ph++) begin
      write_size(REG_WIDTH, (ph % 3 == 0) ? $urandom : $urandom_range(0, 1 << 20));
      write_size(REG_HEIGHT, (ph == 5) ? 32'hffffffff : $urandom_range(0, 1 << 20));
      write_size(REG_DEPTH, (ph == 4) ? 0 : $urandom);
      chaos_stall = (ph != 2);
      if (ph == 3) hold_off = 200;   // back-pressure fills the pipe while we keep offering
      burst_run(156);
      // Pause until every expected support has arrived.
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d queries over %0d size writes with extremes, ties and saturation.",
             queries_sent, size_sets);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
